[design/cst_pkg.sv]
// Shared types, token codes and keyword table for the character stream tokenizer.
// No dependencies; every other design file imports this package.
package cst_pkg;

  localparam int KW_CHARS   = 8;                 // identifier characters kept for keyword match
  localparam int KW_IDX_W   = $clog2(KW_CHARS);
  localparam int KW_MAX_LEN = 7;                 // longest keyword
  localparam int KW_COUNT   = 11;
  localparam int LEN_W      = 16;                // lexeme length counter width
  localparam int IQ_DEPTH   = 2;                 // front-to-back queue
  localparam int OQ_DEPTH   = 4;                 // result queue

  localparam logic [4:0] TK_PROGRAM = 5'd0;
  localparam logic [4:0] TK_PRINT   = 5'd1;
  localparam logic [4:0] TK_INT     = 5'd2;
  localparam logic [4:0] TK_END     = 5'd3;
  localparam logic [4:0] TK_FLOAT   = 5'd4;
  localparam logic [4:0] TK_ELSE    = 5'd5;
  localparam logic [4:0] TK_IF      = 5'd6;
  localparam logic [4:0] TK_THEN    = 5'd7;
  localparam logic [4:0] TK_BOOL    = 5'd8;
  localparam logic [4:0] TK_IDENT   = 5'd9;
  localparam logic [4:0] TK_ICONST  = 5'd10;
  localparam logic [4:0] TK_RCONST  = 5'd11;
  localparam logic [4:0] TK_SCONST  = 5'd12;
  localparam logic [4:0] TK_BCONST  = 5'd13;
  localparam logic [4:0] TK_PLUS    = 5'd14;
  localparam logic [4:0] TK_MINUS   = 5'd15;
  localparam logic [4:0] TK_MULT    = 5'd16;
  localparam logic [4:0] TK_DIV     = 5'd17;
  localparam logic [4:0] TK_ASSOP   = 5'd18;
  localparam logic [4:0] TK_EQUAL   = 5'd19;
  localparam logic [4:0] TK_GTHAN   = 5'd20;
  localparam logic [4:0] TK_LTHAN   = 5'd21;
  localparam logic [4:0] TK_AND     = 5'd22;
  localparam logic [4:0] TK_OR      = 5'd23;
  localparam logic [4:0] TK_NOT     = 5'd24;
  localparam logic [4:0] TK_COMMA   = 5'd25;
  localparam logic [4:0] TK_LPAREN  = 5'd26;
  localparam logic [4:0] TK_RPAREN  = 5'd27;
  localparam logic [4:0] TK_SEMICOL = 5'd28;
  localparam logic [4:0] TK_ERR     = 5'd29;
  localparam logic [4:0] TK_DONE    = 5'd30;

  // Keywords, right-aligned and zero padded on the left
  localparam logic [8*KW_MAX_LEN-1:0] KW_WORD [KW_COUNT] = '{
    "PROGRAM", "PRINT", "INT", "END", "FLOAT", "ELSE", "IF", "THEN", "TRUE", "FALSE", "BOOL"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd7, 4'd5, 4'd3, 4'd3, 4'd5, 4'd4, 4'd2, 4'd4, 4'd4, 4'd5, 4'd4
  };
  localparam logic [4:0] KW_KIND [KW_COUNT] = '{
    TK_PROGRAM, TK_PRINT, TK_INT, TK_END, TK_FLOAT, TK_ELSE, TK_IF, TK_THEN,
    TK_BCONST, TK_BCONST, TK_BOOL
  };

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] line_number;
    logic [31:0] lexeme_start;
    logic [15:0] lexeme_length;
    logic        open_comment;
    logic        last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    CLS_SPACE, CLS_NL, CLS_LETTER, CLS_UNDER, CLS_DIGIT, CLS_AT, CLS_QUOTE, CLS_DOT,
    CLS_SLASH, CLS_STAR, CLS_EQ, CLS_AMP, CLS_BAR, CLS_OTHER
  } char_cls_t;

  // Classified character as it travels from front to back
  typedef struct packed {
    logic       eoi;
    logic [7:0] upper;
    char_cls_t  cls;
    logic [4:0] single_kind;   // token of a one-character lexeme started by this byte
  } cls_item_t;

  typedef enum logic [11:0] {
    M_START   = 12'b0000_0000_0001,
    M_ID      = 12'b0000_0000_0010,
    M_STR     = 12'b0000_0000_0100,
    M_INT     = 12'b0000_0000_1000,
    M_FDOT    = 12'b0000_0001_0000,
    M_FRAC    = 12'b0000_0010_0000,
    M_COMMENT = 12'b0000_0100_0000,
    M_CSTAR   = 12'b0000_1000_0000,
    M_SLASH   = 12'b0001_0000_0000,
    M_EQ      = 12'b0010_0000_0000,
    M_AMP     = 12'b0100_0000_0000,
    M_BAR     = 12'b1000_0000_0000
  } lex_mode_t;

  // Up to two results from one step; v1 implies v0
  typedef struct packed {
    logic      v0;
    logic      v1;
    out_item_t r0;
    out_item_t r1;
  } res_pair_t;

  function automatic logic [4:0] word_kind(input logic [KW_CHARS-1:0][7:0] pw,
                                           input logic [LEN_W-1:0] len,
                                           input logic too_long);
    logic [8*KW_MAX_LEN-1:0] cand;
    logic [4:0]              kind;
    cand = '0;
    kind = TK_IDENT;
    // pack the first len characters right-aligned, like the table
    for (int j = 0; j < KW_MAX_LEN; j++) begin
      if (LEN_W'(j) < len) cand = {cand[8*KW_MAX_LEN-9:0], pw[j]};
    end
    if (!too_long && len <= LEN_W'(KW_MAX_LEN)) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (len == LEN_W'(KW_LEN[k]) && cand == KW_WORD[k]) kind = KW_KIND[k];
      end
    end
    return kind;
  endfunction

endpackage

[design/cst_front.sv]
// Front end: accepts input transactions, classifies each byte and queues it.
// Depends on cst_pkg.
module cst_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cst_pkg::in_item_t    in_item,
  output logic                 q_valid,
  output cst_pkg::cls_item_t   q_item,
  input  logic                 q_pop
);
  import cst_pkg::*;

  localparam int PW = (IQ_DEPTH > 1) ? $clog2(IQ_DEPTH) : 1;
  localparam int CW = $clog2(IQ_DEPTH + 1);

  cls_item_t       mem_r [IQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            accept;
  cls_item_t       cls_in;

  function automatic cls_item_t classify(input logic [7:0] c, input logic eoi);
    cls_item_t r;
    r.eoi   = eoi;
    r.upper = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    priority if (c == 8'h0A)                          r.cls = CLS_NL;
    else if (c == " " || (c >= 8'd9 && c <= 8'd13))   r.cls = CLS_SPACE;
    else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) r.cls = CLS_LETTER;
    else if (c >= "0" && c <= "9")                    r.cls = CLS_DIGIT;
    else if (c == "_")                                r.cls = CLS_UNDER;
    else if (c == "@")                                r.cls = CLS_AT;
    else if (c == 8'h22)                              r.cls = CLS_QUOTE;
    else if (c == ".")                                r.cls = CLS_DOT;
    else if (c == "/")                                r.cls = CLS_SLASH;
    else if (c == "*")                                r.cls = CLS_STAR;
    else if (c == "=")                                r.cls = CLS_EQ;
    else if (c == "&")                                r.cls = CLS_AMP;
    else if (c == "|")                                r.cls = CLS_BAR;
    else                                              r.cls = CLS_OTHER;
    unique case (c)
      "+":     r.single_kind = TK_PLUS;
      "-":     r.single_kind = TK_MINUS;
      "*":     r.single_kind = TK_MULT;
      "(":     r.single_kind = TK_LPAREN;
      ")":     r.single_kind = TK_RPAREN;
      ";":     r.single_kind = TK_SEMICOL;
      ",":     r.single_kind = TK_COMMA;
      ">":     r.single_kind = TK_GTHAN;
      "<":     r.single_kind = TK_LTHAN;
      "!":     r.single_kind = TK_NOT;
      default: r.single_kind = TK_ERR;
    endcase
    return r;
  endfunction

  assign in_stall = (count_r == CW'(IQ_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign cls_in   = classify(in_item.char_code, in_item.end_of_input);
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = accept ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CW'(accept) - CW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) mem_r[wr_ptr_r] <= cls_in;
  end

endmodule

[design/cst_lexer.sv]
// Back end: lexer state machine, one classified byte per cycle given oq_room,
// up to two tokens. Also holds the first-line-number register. Depends on cst_pkg.
module cst_lexer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data,
  input  logic                 q_valid,
  input  cst_pkg::cls_item_t   q_item,
  output logic                 q_pop,
  input  logic                 oq_room,
  output cst_pkg::res_pair_t   res
);
  import cst_pkg::*;

  lex_mode_t                 mode_r, mode_nxt;
  logic [15:0]               first_line_r;
  logic [15:0]               line_r, line_nxt;
  logic [31:0]               pos_r, pos_nxt;
  logic [31:0]               tbeg_r, tbeg_nxt;
  logic [LEN_W-1:0]          tlen_r, tlen_nxt;
  logic [KW_CHARS-1:0][7:0]  prefix_r, prefix_nxt;
  logic                      wtl_r, wtl_nxt;
  logic                      go, redo, restart;
  logic                      e0_v, e1_v, e0_oc, e1_oc;
  logic [4:0]                e0_kind, e1_kind;
  logic [31:0]               e0_start, e1_start;
  logic [LEN_W-1:0]          e0_len, e1_len;
  out_item_t                 o0, o1;

  function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] v);
    return (v != '1) ? v + LEN_W'(1) : v;
  endfunction

  function automatic logic [15:0] line_inc(input logic [15:0] v);
    return (v != '1) ? v + 16'd1 : v;
  endfunction

  assign cfg_ready = 1'b1;
  assign go        = q_valid && oq_room;
  assign q_pop     = go;

  always_comb begin
    mode_nxt   = mode_r;
    line_nxt   = line_r;
    pos_nxt    = pos_r;
    tbeg_nxt   = tbeg_r;
    tlen_nxt   = tlen_r;
    prefix_nxt = prefix_r;
    wtl_nxt    = wtl_r;
    redo       = 1'b0;
    restart    = 1'b0;
    e0_v = 1'b0; e0_kind = TK_ERR; e0_start = tbeg_r; e0_len = tlen_r; e0_oc = 1'b0;
    e1_v = 1'b0; e1_kind = TK_ERR; e1_start = pos_r;  e1_len = LEN_W'(1); e1_oc = 1'b0;
    if (go) begin
      if (q_item.eoi) begin
        // flush the pending token, then report done
        e1_v    = 1'b1;
        e1_kind = TK_DONE;
        e1_len  = '0;
        restart = 1'b1;
        unique case (mode_r)
          M_ID: begin
            e0_v = 1'b1; e0_kind = word_kind(prefix_r, tlen_r, wtl_r);
          end
          M_INT:  begin e0_v = 1'b1; e0_kind = TK_ICONST; end
          M_FRAC: begin e0_v = 1'b1; e0_kind = TK_RCONST; end
          M_FDOT, M_STR: begin
            e0_v = 1'b1; e0_len = len_inc(tlen_r);
          end
          M_SLASH: begin e0_v = 1'b1; e0_kind = TK_DIV;   e0_len = LEN_W'(1); end
          M_EQ:    begin e0_v = 1'b1; e0_kind = TK_ASSOP; e0_len = LEN_W'(1); end
          M_AMP, M_BAR: begin e0_v = 1'b1; e0_len = LEN_W'(1); end
          M_COMMENT, M_CSTAR: e1_oc = 1'b1;
          default: ;
        endcase
      end else begin
        unique case (mode_r)
          M_START: redo = 1'b1;
          M_ID: begin
            if (q_item.cls == CLS_LETTER || q_item.cls == CLS_DIGIT ||
                q_item.cls == CLS_UNDER || q_item.cls == CLS_AT) begin
              if (tlen_r < LEN_W'(KW_CHARS)) prefix_nxt[tlen_r[KW_IDX_W-1:0]] = q_item.upper;
              else wtl_nxt = 1'b1;
              tlen_nxt = len_inc(tlen_r);
            end else begin
              e0_v = 1'b1; e0_kind = word_kind(prefix_r, tlen_r, wtl_r);
              mode_nxt = M_START; redo = 1'b1;
            end
          end
          M_STR: begin
            if (q_item.cls == CLS_NL) begin
              // error includes the opening quote
              e0_v = 1'b1; e0_len = len_inc(tlen_r);
              mode_nxt = M_START;
              line_nxt = line_inc(line_r);
            end else if (q_item.cls == CLS_QUOTE) begin
              e0_v = 1'b1; e0_kind = TK_SCONST;
              e0_start = (tbeg_r != '1) ? tbeg_r + 32'd1 : tbeg_r;
              mode_nxt = M_START;
            end else begin
              tlen_nxt = len_inc(tlen_r);
            end
          end
          M_INT: begin
            if (q_item.cls == CLS_DIGIT) tlen_nxt = len_inc(tlen_r);
            else if (q_item.cls == CLS_DOT) mode_nxt = M_FDOT;
            else begin
              e0_v = 1'b1; e0_kind = TK_ICONST;
              mode_nxt = M_START; redo = 1'b1;
            end
          end
          M_FDOT: begin
            if (q_item.cls == CLS_DIGIT) begin
              // count the dot and this digit
              tlen_nxt = len_inc(len_inc(tlen_r));
              mode_nxt = M_FRAC;
            end else begin
              tlen_nxt = len_inc(tlen_r);
              e0_v = 1'b1; e0_len = len_inc(tlen_r);
              mode_nxt = M_START; redo = 1'b1;
            end
          end
          M_FRAC: begin
            if (q_item.cls == CLS_DIGIT) tlen_nxt = len_inc(tlen_r);
            else if (q_item.cls == CLS_DOT) begin
              e0_v = 1'b1; e0_len = len_inc(tlen_r);
              mode_nxt = M_START;
            end else begin
              e0_v = 1'b1; e0_kind = TK_RCONST;
              mode_nxt = M_START; redo = 1'b1;
            end
          end
          M_COMMENT: begin
            if (q_item.cls == CLS_NL) line_nxt = line_inc(line_r);
            else if (q_item.cls == CLS_STAR) mode_nxt = M_CSTAR;
          end
          M_CSTAR: begin
            if (q_item.cls == CLS_SLASH) mode_nxt = M_START;
            else if (q_item.cls == CLS_STAR) mode_nxt = M_CSTAR;
            else begin
              mode_nxt = M_COMMENT;
              if (q_item.cls == CLS_NL) line_nxt = line_inc(line_r);
            end
          end
          M_SLASH: begin
            if (q_item.cls == CLS_STAR) mode_nxt = M_COMMENT;
            else begin
              e0_v = 1'b1; e0_kind = TK_DIV; e0_len = LEN_W'(1);
              mode_nxt = M_START; redo = 1'b1;
            end
          end
          M_EQ: begin
            mode_nxt = M_START;
            e0_v     = 1'b1;
            if (q_item.cls == CLS_EQ) begin
              e0_kind = TK_EQUAL; e0_len = LEN_W'(2);
            end else begin
              e0_kind = TK_ASSOP; e0_len = LEN_W'(1); redo = 1'b1;
            end
          end
          M_AMP, M_BAR: begin
            mode_nxt = M_START;
            e0_v     = 1'b1;
            if ((mode_r == M_AMP && q_item.cls == CLS_AMP) ||
                (mode_r == M_BAR && q_item.cls == CLS_BAR)) begin
              e0_kind = (mode_r == M_AMP) ? TK_AND : TK_OR; e0_len = LEN_W'(2);
            end else begin
              // lone & or |: report it as an error and take this byte fresh
              e0_len = LEN_W'(1); redo = 1'b1;
            end
          end
          default: mode_nxt = M_START;
        endcase

        if (redo) begin
          if (q_item.cls == CLS_NL) line_nxt = line_inc(line_r);
          unique case (q_item.cls)
            CLS_SPACE, CLS_NL: ;
            CLS_LETTER, CLS_UNDER: begin
              tbeg_nxt = pos_r; tlen_nxt = LEN_W'(1);
              prefix_nxt[0] = q_item.upper;
              wtl_nxt  = 1'b0;
              mode_nxt = M_ID;
            end
            CLS_QUOTE: begin
              tbeg_nxt = pos_r; tlen_nxt = '0; mode_nxt = M_STR;
            end
            CLS_DIGIT: begin
              tbeg_nxt = pos_r; tlen_nxt = LEN_W'(1); mode_nxt = M_INT;
            end
            CLS_SLASH: begin
              tbeg_nxt = pos_r; tlen_nxt = LEN_W'(1); mode_nxt = M_SLASH;
            end
            CLS_EQ: begin
              tbeg_nxt = pos_r; tlen_nxt = LEN_W'(1); mode_nxt = M_EQ;
            end
            CLS_AMP: begin
              tbeg_nxt = pos_r; tlen_nxt = LEN_W'(1); mode_nxt = M_AMP;
            end
            CLS_BAR: begin
              tbeg_nxt = pos_r; tlen_nxt = LEN_W'(1); mode_nxt = M_BAR;
            end
            default: begin
              tbeg_nxt = pos_r; tlen_nxt = LEN_W'(1);
              e1_v = 1'b1; e1_kind = q_item.single_kind;
            end
          endcase
        end
        pos_nxt = (pos_r != '1) ? pos_r + 32'd1 : pos_r;
      end

      if (restart) begin
        mode_nxt = M_START;
        line_nxt = first_line_r;
        pos_nxt  = '0;
        tbeg_nxt = '0;
        tlen_nxt = '0;
        wtl_nxt  = 1'b0;
      end
    end
  end

  always_comb begin
    o0.token_kind    = e0_kind;
    o0.line_number   = line_r;
    o0.lexeme_start  = e0_start;
    o0.lexeme_length = 16'(e0_len);
    o0.open_comment  = e0_oc;
    o0.last_result   = !e1_v;
    o1.token_kind    = e1_kind;
    o1.line_number   = line_r;
    o1.lexeme_start  = e1_start;
    o1.lexeme_length = 16'(e1_len);
    o1.open_comment  = e1_oc;
    o1.last_result   = 1'b1;
    res.v0 = e0_v || e1_v;
    res.v1 = e0_v && e1_v;
    res.r0 = e0_v ? o0 : o1;
    res.r1 = o1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_START;
      first_line_r <= 16'd1;
      line_r       <= 16'd1;
      pos_r        <= '0;
      tbeg_r       <= '0;
      tlen_r       <= '0;
      wtl_r        <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      tbeg_r <= tbeg_nxt;
      tlen_r <= tlen_nxt;
      wtl_r  <= wtl_nxt;
      if (cfg_valid && cfg_ready) begin
        first_line_r <= cfg_data;
        // load the line counter too while nothing has been consumed
        if (pos_r == '0 && mode_r == M_START) line_r <= cfg_data;
        else line_r <= line_nxt;
      end else begin
        line_r <= line_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    prefix_r <= prefix_nxt;
  end

endmodule

[design/cst_outq.sv]
// Result queue: takes up to two tokens per cycle from the lexer, delivers one
// per cycle while out_stall is low. Depends on cst_pkg.
module cst_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cst_pkg::res_pair_t   push,
  output logic                 oq_room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cst_pkg::out_item_t   out_item
);
  import cst_pkg::*;

  localparam int PW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  out_item_t      mem_r [OQ_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           pop;

  assign out_valid = (count_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // room for a full pair without counting this cycle's pop
  assign oq_room   = (count_r <= CW'(OQ_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.v0) + PW'(push.v1);
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CW'(push.v0) + CW'(push.v1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wr_ptr_r] <= push.r0;
    if (push.v1) mem_r[wr_ptr_r + PW'(1)] <= push.r1;
  end

endmodule

[design/character_stream_tokenizer_top.sv]
// Top level of the character stream tokenizer: front queue, lexer, result queue.
// Depends on cst_pkg, cst_front, cst_lexer, cst_outq.
//
//   port group  direction  flow control   payload
//   in_*        input      valid/stall    in_item_t  (byte or end mark)
//   out_*       output     valid/stall    out_item_t (one token)
//   cfg_*       input      valid/ready    first line number, 16 bits
//
// One byte per clock is sustained while the result queue has room; the lexer
// takes one queued byte per cycle while oq_room is set. A byte that yields two
// tokens pushes both into the 4-entry result queue, which delivers one at a time.
// Bytes are registered in the front queue and tokens in the result queue.
// Reset is synchronous, active low; the block is ready in the next cycle.
// in_stall rises only when the 2-entry front queue is full.
module character_stream_tokenizer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cst_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cst_pkg::out_item_t   out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);
  import cst_pkg::*;

  logic       q_valid;
  cls_item_t  q_item;
  logic       lex_pop;
  logic       oq_room;
  res_pair_t  res;

  cst_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (lex_pop)
  );

  cst_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (lex_pop),
    .oq_room   (oq_room),
    .res       (res)
  );

  cst_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .oq_room   (oq_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    res.v1 |-> res.v0)
    else $error("second token without a first");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    lex_pop |-> q_valid)
    else $error("lexer popped an empty queue");

  a_res_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
    res.v0 |-> lex_pop)
    else $error("token produced without a byte");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.token_kind == TK_DONE) |-> out_item.last_result)
    else $error("done token not marked last");

  a_oc_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.open_comment) |-> out_item.token_kind == TK_DONE)
    else $error("open comment flag on a non-done token");

endmodule

[tb/character_stream_tokenizer_top_tb.sv]
// Self-checking testbench for character_stream_tokenizer_top: feeds byte streams, predicts
// the token sequence in a scoreboard class and compares every token field by field.
// Depends on cst_pkg and the tokenizer RTL only.
module character_stream_tokenizer_top_tb;
  import cst_pkg::*;

  localparam int WORD_KEEP = 8;   // identifier characters kept for keyword match

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  bit quiet = 1'b0;   // no idling on either side while set
  int stall_left = 0;

  character_stream_tokenizer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  class token_tracker;
    out_item_t   pending_tokens[$];
    out_item_t   step_tokens[$];
    int          mismatches;
    logic [15:0] first_line;
    lex_mode_t   mode;
    logic [15:0] line_cnt;
    logic [31:0] pos;
    logic [31:0] tok_begin;
    logic [15:0] tok_len;
    logic [7:0]  prefix [WORD_KEEP];
    bit          too_long;

    function new();
      mismatches = 0;
      first_line = 16'd1;
      restart();
    endfunction

    function void restart();
      mode = M_START;
      line_cnt = first_line;
      pos = '0;
      tok_begin = '0;
      tok_len = '0;
      too_long = 1'b0;
      foreach (prefix[i]) prefix[i] = '0;
    endfunction

    function void load_first_line(logic [15:0] v);
      first_line = v;
      if (pos == 0 && mode == M_START) line_cnt = v;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit is_space(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function logic [7:0] upcase(logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function void line_up();
      if (line_cnt != 16'hFFFF) line_cnt++;
    endfunction

    function void push_token(logic [4:0] kind, logic [31:0] start, logic [15:0] len,
                             logic oc);
      out_item_t t;
      if (step_tokens.size() >= 2) return;
      t.token_kind    = kind;
      t.line_number   = line_cnt;
      t.lexeme_start  = start;
      t.lexeme_length = len;
      t.open_comment  = oc;
      t.last_result   = 1'b0;
      step_tokens.push_back(t);
    endfunction

    function logic [4:0] classify_word();
      logic [63:0] w;
      if (too_long || tok_len > WORD_KEEP) return TK_IDENT;
      w = '0;
      for (int i = 0; i < tok_len; i++) w = {w[55:0], prefix[i]};
      // word characters are never zero, so the padding also fixes the length
      case (w)
        "PROGRAM": return TK_PROGRAM;
        "PRINT":   return TK_PRINT;
        "INT":     return TK_INT;
        "END":     return TK_END;
        "FLOAT":   return TK_FLOAT;
        "ELSE":    return TK_ELSE;
        "IF":      return TK_IF;
        "THEN":    return TK_THEN;
        "BOOL":    return TK_BOOL;
        "TRUE":    return TK_BCONST;
        "FALSE":   return TK_BCONST;
        default:   return TK_IDENT;
      endcase
    endfunction

    function logic [4:0] single_kind(logic [7:0] c);
      case (c)
        "+":     return TK_PLUS;
        "-":     return TK_MINUS;
        "*":     return TK_MULT;
        "(":     return TK_LPAREN;
        ")":     return TK_RPAREN;
        ";":     return TK_SEMICOL;
        ",":     return TK_COMMA;
        ">":     return TK_GTHAN;
        "<":     return TK_LTHAN;
        "!":     return TK_NOT;
        default: return TK_ERR;
      endcase
    endfunction

    function void start_byte(logic [7:0] c);
      if (c == 8'h0A) line_up();
      if (is_space(c)) return;
      tok_begin = pos;
      tok_len = 16'd1;
      if (is_alpha(c) || c == "_") begin
        prefix[0] = upcase(c);
        too_long = 1'b0;
        mode = M_ID;
      end else if (c == "\"") begin
        tok_len = '0;
        mode = M_STR;
      end else if (is_digit(c)) begin
        mode = M_INT;
      end else if (c == "/") begin
        mode = M_SLASH;
      end else if (c == "=") begin
        mode = M_EQ;
      end else if (c == "&") begin
        mode = M_AMP;
      end else if (c == "|") begin
        mode = M_BAR;
      end else begin
        push_token(single_kind(c), tok_begin, 16'd1, 1'b0);
      end
    endfunction

    // One pass over a byte; returns 1 when the byte must be seen again in the new mode.
    function bit lex_byte(logic [7:0] c);
      lex_mode_t m;
      m = mode;
      // lookahead modes fall back to start unless a branch below sets another mode
      if (!(m inside {M_START, M_ID, M_STR, M_INT, M_FRAC, M_COMMENT})) mode = M_START;
      case (m)
        M_ID: begin
          if (is_alpha(c) || is_digit(c) || c == "_" || c == "@") begin
            if (tok_len < WORD_KEEP) prefix[tok_len] = upcase(c);
            else too_long = 1'b1;
            tok_len = bump(tok_len);
            return 1'b0;
          end
          push_token(classify_word(), tok_begin, tok_len, 1'b0);
          mode = M_START;
          return 1'b1;
        end
        M_STR: begin
          if (c == 8'h0A) begin
            push_token(TK_ERR, tok_begin, bump(tok_len), 1'b0);
            mode = M_START;
            line_up();
          end else if (c == "\"") begin
            push_token(TK_SCONST, (tok_begin != '1) ? tok_begin + 32'd1 : tok_begin,
                       tok_len, 1'b0);
            mode = M_START;
          end else begin
            tok_len = bump(tok_len);
          end
          return 1'b0;
        end
        M_INT: begin
          if (is_digit(c)) begin
            tok_len = bump(tok_len);
            return 1'b0;
          end
          if (c == ".") begin
            mode = M_FDOT;
            return 1'b0;
          end
          push_token(TK_ICONST, tok_begin, tok_len, 1'b0);
          mode = M_START;
          return 1'b1;
        end
        M_FDOT: begin
          tok_len = bump(tok_len);
          if (is_digit(c)) begin
            mode = M_FRAC;
            return 1'b1;
          end
          push_token(TK_ERR, tok_begin, tok_len, 1'b0);
          return 1'b1;
        end
        M_FRAC: begin
          if (is_digit(c)) begin
            tok_len = bump(tok_len);
            return 1'b0;
          end
          mode = M_START;
          if (c == ".") begin
            push_token(TK_ERR, tok_begin, bump(tok_len), 1'b0);
            return 1'b0;
          end
          push_token(TK_RCONST, tok_begin, tok_len, 1'b0);
          return 1'b1;
        end
        M_COMMENT: begin
          if (c == 8'h0A) line_up();
          else if (c == "*") mode = M_CSTAR;
          return 1'b0;
        end
        M_CSTAR: begin
          if (c == "/") return 1'b0;
          mode = M_COMMENT;
          return 1'b1;
        end
        M_SLASH: begin
          if (c == "*") begin
            mode = M_COMMENT;
            return 1'b0;
          end
          push_token(TK_DIV, tok_begin, 16'd1, 1'b0);
          return 1'b1;
        end
        M_EQ: begin
          if (c == "=") begin
            push_token(TK_EQUAL, tok_begin, 16'd2, 1'b0);
            return 1'b0;
          end
          push_token(TK_ASSOP, tok_begin, 16'd1, 1'b0);
          return 1'b1;
        end
        M_AMP, M_BAR: begin
          if ((m == M_AMP && c == "&") || (m == M_BAR && c == "|")) begin
            push_token((m == M_AMP) ? TK_AND : TK_OR, tok_begin, 16'd2, 1'b0);
            return 1'b0;
          end
          push_token(TK_ERR, tok_begin, 16'd1, 1'b0);
          return 1'b1;
        end
        default: begin
          mode = M_START;
          start_byte(c);
          return 1'b0;
        end
      endcase
    endfunction

    function void finish_stream();
      logic oc;
      oc = 1'b0;
      case (mode)
        M_ID:             push_token(classify_word(), tok_begin, tok_len, 1'b0);
        M_INT:            push_token(TK_ICONST, tok_begin, tok_len, 1'b0);
        M_FRAC:           push_token(TK_RCONST, tok_begin, tok_len, 1'b0);
        M_FDOT, M_STR:    push_token(TK_ERR, tok_begin, bump(tok_len), 1'b0);
        M_SLASH:          push_token(TK_DIV, tok_begin, 16'd1, 1'b0);
        M_EQ:             push_token(TK_ASSOP, tok_begin, 16'd1, 1'b0);
        M_AMP, M_BAR:     push_token(TK_ERR, tok_begin, 16'd1, 1'b0);
        M_COMMENT, M_CSTAR: oc = 1'b1;
        default: ;
      endcase
      push_token(TK_DONE, pos, '0, oc);
      restart();
    endfunction

    function void predict_tokens(in_item_t it);
      out_item_t t;
      step_tokens.delete();
      if (it.end_of_input) begin
        finish_stream();
      end else begin
        for (int k = 0; k < 3; k++) if (!lex_byte(it.char_code)) break;
        if (pos != '1) pos++;
      end
      if (step_tokens.size() > 0) begin
        t = step_tokens.pop_back();
        t.last_result = 1'b1;
        step_tokens.push_back(t);
      end
      foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
    endfunction

    function string show(out_item_t t);
      return $sformatf("kind=%0d line=%0d start=%0d len=%0d open=%0b last=%0b",
                       t.token_kind, t.line_number, t.lexeme_start, t.lexeme_length,
                       t.open_comment, t.last_result);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_token(out_item_t got);
      out_item_t want;
      if (pending_tokens.size() == 0) begin
        flag($sformatf("unexpected token: %s", show(got)));
        return;
      end
      want = pending_tokens.pop_front();
      if (got.token_kind !== want.token_kind || got.line_number !== want.line_number ||
          got.lexeme_start !== want.lexeme_start ||
          got.lexeme_length !== want.lexeme_length ||
          got.open_comment !== want.open_comment || got.last_result !== want.last_result)
        flag($sformatf("token differs: expected %s, got %s", show(want), show(got)));
    endfunction
  endclass

  token_tracker sb = new();

  always #1 clk = ~clk;

  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(24, 4);
  endfunction

  // Take tokens and stall the result channel at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_token(out_item);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= idle_len();
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.predict_tokens(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item({s[i], 1'b0});
  endtask

  // Hold the input until every predicted token has come out, then wait extra cycles
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_tokens.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_first_line(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.load_first_line(v);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] any_letter();
    return 8'($urandom_range(1) ? "A" : "a") + 8'($urandom_range(25));
  endfunction

  function automatic void add_digits(ref in_item_t q[$], input int n);
    repeat (n) q.push_back({8'("0" + $urandom_range(9)), 1'b0});
  endfunction

  // One lexically meaningful piece of text, sometimes broken, plus an optional separator
  function automatic void build_fragment(ref in_item_t q[$]);
    string words[11] = '{"PROGRAM", "PRINT", "INT", "END", "FLOAT", "ELSE", "IF", "THEN",
                         "BOOL", "TRUE", "FALSE"};
    string ops[17] = '{"+", "-", "*", "/", "=", "==", ">", "<", "&&", "||", "!", ",",
                       "(", ")", ";", "&", "|"};
    logic [7:0] ws[6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
    string w;
    logic [7:0] c;
    int r, n, form;
    q.delete();
    r = $urandom_range(99);
    if (r < 14) begin
      w = words[$urandom_range(10)];
      for (int i = 0; i < w.len(); i++) begin
        c = w[i];
        if ($urandom_range(1)) c = c + 8'd32;
        q.push_back({c, 1'b0});
      end
    end else if (r < 28) begin
      n = ($urandom_range(99) < 85) ? $urandom_range(6, 1) : $urandom_range(14, 7);
      q.push_back({($urandom_range(9) == 0) ? 8'("_") : any_letter(), 1'b0});
      repeat (n - 1) begin
        form = $urandom_range(99);
        if (form < 60) c = any_letter();
        else if (form < 85) c = 8'("0" + $urandom_range(9));
        else if (form < 93) c = "_";
        else c = "@";
        q.push_back({c, 1'b0});
      end
    end else if (r < 40) begin
      form = $urandom_range(5);
      if (form == 5) begin
        q.push_back({8'("."), 1'b0});
        if ($urandom_range(1)) add_digits(q, 1);
      end else begin
        add_digits(q, $urandom_range(6, 1));
        if (form >= 2) begin
          q.push_back({8'("."), 1'b0});
          if (form != 4 || $urandom_range(1)) add_digits(q, $urandom_range(3, 1));
          if (form == 4) begin
            q.push_back({8'("."), 1'b0});
            if ($urandom_range(1)) add_digits(q, $urandom_range(2, 1));
          end
        end
      end
    end else if (r < 50) begin
      q.push_back({8'("\""), 1'b0});
      repeat ($urandom_range(8)) q.push_back({8'($urandom_range(126, 35)), 1'b0});
      if ($urandom_range(7) == 0) q.push_back({8'h0A, 1'b0});
      else q.push_back({8'("\""), 1'b0});
    end else if (r < 68) begin
      w = ops[$urandom_range(16)];
      for (int i = 0; i < w.len(); i++) q.push_back({w[i], 1'b0});
    end else if (r < 76) begin
      q.push_back({8'("/"), 1'b0});
      q.push_back({8'("*"), 1'b0});
      repeat ($urandom_range(10)) begin
        form = $urandom_range(4);
        if (form == 0) c = "*";
        else if (form == 1) c = "/";
        else if (form == 2) c = 8'h0A;
        else if (form == 3) c = " ";
        else c = any_letter();
        q.push_back({c, 1'b0});
      end
      // leave a comment open now and then so that end of input finds it
      if ($urandom_range(29) != 0) begin
        q.push_back({8'("*"), 1'b0});
        q.push_back({8'("/"), 1'b0});
      end
    end else if (r < 88) begin
      q.push_back({ws[$urandom_range(5)], 1'b0});
    end else if (r < 95) begin
      q.push_back({8'($urandom_range(255)), 1'b0});
    end else begin
      q.push_back({8'($urandom_range(255)), 1'b1});
    end
    if ($urandom_range(99) < 55) q.push_back({($urandom_range(3) == 0) ? 8'h0A : 8'h20, 1'b0});
  endfunction

  task automatic run_text(input int n_items);
    in_item_t frag[$];
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(24) == 0) quiet = !quiet;
      if ($urandom_range(149) == 0) drain(0);
      build_fragment(frag);
      foreach (frag[i]) send_item(frag[i]);
      sent += frag.size();
    end
  endtask

  initial begin
    logic [15:0] line_setting [6];
    line_setting = '{16'd0, 16'hFFFF, 16'($urandom), 16'd1, 16'($urandom), 16'hFFFE};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed text: line counter saturation, lone ampersand and bar, string broken
    // by a newline, lone dot, high and zero bytes, comment left open at end of input
    set_first_line(16'hFFFE);
    send_text("IF 9.5&|\n\"s\n.");
    send_item({8'hFF, 1'b0});
    send_item({8'h00, 1'b0});
    send_text("@==/*\n");
    send_item({8'h5A, 1'b1});
    drain(10);

    for (int p = 0; p < 6; p++) begin
      set_first_line(line_setting[p]);
      run_text(110);
      if (p == 0) drain(0);
      run_text(115);
      // phase 2 ends mid-stream, so the next write must not move the line counter
      if (p != 2) send_item({8'($urandom_range(255)), 1'b1});
      drain(10);
    end

    if (sb.mismatches == 0 && sb.pending_tokens.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
